FILE: rtl/qpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package qpd_pkg;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_MODE  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OUTPUT_LIMIT = 8'd1;

    localparam logic [7:0] CHAR_EQ    = 8'h3D;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_UNDER = 8'h5F;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] HEX_BAD    = 8'hFF;
    localparam int         NIBBLE_W   = 4;

    typedef enum logic [3:0] {
        PH_PLAIN = 4'b0001,
        PH_EQ    = 4'b0010,
        PH_DIGIT = 4'b0100,
        PH_SOFT  = 4'b1000
    } phase_t;

    typedef struct packed {
        phase_t     phase;
        logic [7:0] first_digit;
        logic       halted;
    } qpd_state_t;

    typedef struct packed {
        logic [7:0] enc_byte;
        logic       last_byte;
    } qpd_in_t;

    typedef struct packed {
        logic        has_byte;
        logic [7:0]  data_byte;
        logic        message_done;
        logic [15:0] decoded_count;
    } qpd_out_t;

    function automatic logic [7:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        v = HEX_BAD;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = c - 8'h30;
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = c - 8'h37;
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            v = c - 8'h57;
        end
        return v;
    endfunction

    function automatic logic is_line_end(input logic [7:0] c);
        return (c == CHAR_CR) || (c == CHAR_LF);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/qpd_step.sv
`timescale 1ns / 1ps
`default_nettype none

module qpd_step #(
    parameter int COUNT_BITS = 16
) (
    input  var qpd_pkg::qpd_state_t st,
    input  var logic [COUNT_BITS-1:0] count,
    input  var qpd_pkg::qpd_in_t      item,
    input  var logic                  header_mode,
    input  var logic [15:0]           output_limit,
    output qpd_pkg::qpd_state_t       st_next,
    output logic [COUNT_BITS-1:0]     count_next,
    output qpd_pkg::qpd_out_t         result
);
    import qpd_pkg::*;

    localparam int CMP_W = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;

    logic [7:0]            c;
    logic [7:0]            digit;
    logic                  soft_end;
    logic                  at_limit;
    logic                  give;
    logic                  plain;
    logic [7:0]            byte_v;
    qpd_state_t            nx;
    logic [COUNT_BITS-1:0] cnt;

    assign c        = item.enc_byte;
    assign digit    = hex_value(c);
    assign soft_end = !header_mode && is_line_end(c);
    assign at_limit = (CMP_W'(count) >= CMP_W'(output_limit)) && (output_limit != 16'd0);

    always_comb
    begin
        nx     = st;
        cnt    = count;
        give   = 1'b0;
        plain  = 1'b0;
        byte_v = 8'h00;
        if (!st.halted)
        begin
            unique case (st.phase)
                PH_EQ:
                begin
                    if (soft_end)
                    begin
                        nx.phase = PH_SOFT;
                    end
                    else
                    begin
                        nx.first_digit = digit;
                        nx.phase       = PH_DIGIT;
                    end
                end
                PH_DIGIT:
                begin
                    byte_v   = {st.first_digit[NIBBLE_W-1:0], 4'h0} | digit;
                    give     = 1'b1;
                    nx.phase = PH_PLAIN;
                end
                PH_SOFT:
                begin
                    nx.phase = PH_PLAIN;
                    plain    = !soft_end;
                end
                default:
                begin
                    plain = 1'b1;
                end
            endcase
            if (plain)
            begin
                if (c == CHAR_EQ)
                begin
                    nx.phase = PH_EQ;
                end
                else if (header_mode && c == CHAR_UNDER)
                begin
                    byte_v = CHAR_SPACE;
                    give   = 1'b1;
                end
                else
                begin
                    byte_v = c;
                    give   = 1'b1;
                end
            end
            if (give)
            begin
                if (at_limit)
                begin
                    give      = 1'b0;
                    byte_v    = 8'h00;
                    nx.halted = 1'b1;
                end
                else if (count != {COUNT_BITS{1'b1}})
                begin
                    cnt = count + COUNT_BITS'(1);
                end
            end
        end

        result.has_byte      = give;
        result.data_byte     = give ? byte_v : 8'h00;
        result.message_done  = item.last_byte;
        result.decoded_count = 16'(cnt);

        // end of message clears all message state
        if (item.last_byte)
        begin
            nx.phase       = PH_PLAIN;
            nx.first_digit = 8'h00;
            nx.halted      = 1'b0;
            cnt            = '0;
        end
        st_next    = nx;
        count_next = cnt;
    end

endmodule

`default_nettype wire

FILE: rtl/quoted_printable_decoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// an accepted input beat passes through the input register and then the result register to the output
// throughput: one beat per cycle while the output is not stalled, set by the state update in the step logic
// an input register and a result register part the two channels; a stalled output
// holds the result while the input register still takes one more beat
// reset (async, active low) clears valids, configuration and message state

module quoted_printable_decoder_unit #(
    parameter int COUNT_BITS = 16
) (
    input  var logic                                 clk,
    input  var logic                                 rst_n,
    input  var logic                                 in_valid,
    output logic                                     in_ready,
    input  var qpd_pkg::qpd_in_t                     in_data,
    output logic                                     out_valid,
    input  var logic                                 out_ready,
    output qpd_pkg::qpd_out_t                        out_data,
    input  var logic                                 cfg_valid,
    output logic                                     cfg_ready,
    input  var logic [qpd_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  var logic [qpd_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import qpd_pkg::*;

    logic                  s1_valid_reg;
    qpd_in_t               s1_data_reg;
    logic                  out_valid_reg;
    qpd_out_t              out_data_reg;
    qpd_state_t            st_reg;
    qpd_state_t            st_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  header_mode_reg;
    logic [15:0]           output_limit_reg;
    qpd_out_t              result;
    logic                  advance;

    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

    qpd_step #(
        .COUNT_BITS(COUNT_BITS)
    ) u_step (
        .st          (st_reg),
        .count       (count_reg),
        .item        (s1_data_reg),
        .header_mode (header_mode_reg),
        .output_limit(output_limit_reg),
        .st_next     (st_next),
        .count_next  (count_next),
        .result      (result)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_mode_reg  <= 1'b0;
            output_limit_reg <= 16'd0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_HEADER_MODE:  header_mode_reg  <= cfg_data[0];
                CFG_OUTPUT_LIMIT: output_limit_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_data_reg <= in_data;
        end
    end

    // message state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            st_reg        <= '{phase: PH_PLAIN, first_digit: 8'h00, halted: 1'b0};
            count_reg     <= '0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                st_reg        <= st_next;
                count_reg     <= count_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_data_reg.last_byte |=>
            count_reg == '0 && st_reg.phase == PH_PLAIN && !st_reg.halted)
        else $error("message state not cleared after last beat");

    a_empty_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_data_reg.has_byte |-> out_data_reg.data_byte == 8'h00)
        else $error("data byte nonzero without a decoded byte");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.halted && !(advance && s1_data_reg.last_byte) |=> st_reg.halted)
        else $error("halt released before end of message");

    a_halted_silent: assert property (@(posedge clk) disable iff (!rst_n)
        advance && st_reg.halted |=> !out_data_reg.has_byte)
        else $error("decoded byte given while halted");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with an empty result register");

endmodule

`default_nettype wire
